// ===== hdl/sct_pkg.sv =====
// Shared types, codes and sizes for the source character tokenizer.
`default_nettype none

package sct_pkg;

    localparam int LINE_BITS = 24;
    localparam int LINE_W    = 24;
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    // The queue depth must be a power of two so that the pointers wrap.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 5;

    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_END     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [3:0] KIND_NONE     = 4'd0;
    localparam logic [3:0] KIND_END_STMT = 4'd0;
    localparam logic [3:0] KIND_LOGIC    = 4'd1;
    localparam logic [3:0] KIND_LPAREN   = 4'd2;
    localparam logic [3:0] KIND_RPAREN   = 4'd3;
    localparam logic [3:0] KIND_ASSIGN   = 4'd4;
    localparam logic [3:0] KIND_LBRACE   = 4'd5;
    localparam logic [3:0] KIND_RBRACE   = 4'd6;
    localparam logic [3:0] KIND_LBRACKET = 4'd7;
    localparam logic [3:0] KIND_RBRACKET = 4'd8;
    localparam logic [3:0] KIND_COMMA    = 4'd9;
    localparam logic [3:0] KIND_COLON    = 4'd10;
    localparam logic [3:0] KIND_STRING   = 4'd11;
    localparam logic [3:0] KIND_MATH     = 4'd12;
    localparam logic [3:0] KIND_NUMBER   = 4'd13;
    localparam logic [3:0] KIND_NAME     = 4'd14;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_OPEN_STR   = 3'd1;
    localparam logic [2:0] ERR_SECOND_DOT = 3'd2;
    localparam logic [2:0] ERR_OP_AT_END  = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd4;

    typedef struct packed {
        logic [3:0]        kind;
        logic [7:0]        text;
        logic              has_byte;
        logic              token_end;
        logic [LINE_W-1:0] line;
        logic [2:0]        err;
    } res_t;

    typedef struct packed {
        logic [1:0] num;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

`default_nettype wire

// ===== hdl/sct_front.sv =====
// Front end: accepts input transfers, keeps the scanner state and forms the results.
`default_nettype none

module sct_front
    import sct_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_cmd,
    input  wire logic [7:0]        in_byte,
    input  wire logic [QCNT_W-1:0] q_count,
    output push_t                  push
);

    typedef enum logic [2:0] {
        M_IDLE, M_NUMBER, M_NAME, M_STRING, M_COMMENT, M_OPERATOR, M_HALTED
    } mode_t;

    typedef enum logic [3:0] {
        KW_EMPTY, KW_E, KW_X, KW_XE, KW_A, KW_AN, KW_O, KW_FULL, KW_DEAD
    } kw_t;

    mode_t                mode_reg, mode_next;
    logic                 dot_reg, dot_next;
    logic                 quote_reg, quote_next;
    logic [7:0]           held_reg, held_next;
    kw_t                  kw_reg, kw_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] snl_reg, snl_next;

    logic                 accept;
    logic                 do_start;
    logic                 e0, e1, st_en;
    res_t                 res0, res1, st_res;
    logic [LINE_BITS:0]   line_sum;
    logic [LINE_BITS-1:0] line_inc;
    logic [LINE_BITS-1:0] snl_inc;
    logic [3:0]           pk;
    logic                 pk_ok;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function automatic logic is_math(input logic [7:0] c);
        return c inside {"+", "-", "/", "*", "%"};
    endfunction

    function automatic kw_t kw_step(input kw_t s, input logic [7:0] c);
        kw_t r;
        r = KW_DEAD;
        case (s)
            KW_EMPTY:
            begin
                if (c == "e") r = KW_E;
                else if (c inside {"n", "l", "g"}) r = KW_X;
                else if (c == "a") r = KW_A;
                else if (c == "o") r = KW_O;
            end
            KW_E:    r = (c == "q") ? KW_FULL : KW_DEAD;
            KW_X:    r = (c == "e") ? KW_XE : KW_DEAD;
            KW_XE:   r = (c == "q") ? KW_FULL : KW_DEAD;
            KW_A:    r = (c == "n") ? KW_AN : KW_DEAD;
            KW_AN:   r = (c == "d") ? KW_FULL : KW_DEAD;
            KW_O:    r = (c == "r") ? KW_FULL : KW_DEAD;
            default: r = KW_DEAD;
        endcase
        return r;
    endfunction

    function automatic res_t mk(input logic [3:0] kind, input logic [7:0] text,
                                input logic has, input logic tend, input logic [2:0] err,
                                input logic [LINE_BITS-1:0] ln);
        res_t r;
        r.kind      = kind;
        r.text      = has ? text : 8'd0;
        r.has_byte  = has;
        r.token_end = tend;
        r.line      = LINE_W'(ln);
        r.err       = err;
        return r;
    endfunction

    assign in_ready = (q_count <= QCNT_W'(QDEPTH - 2));
    assign accept   = in_valid && in_ready;

    assign line_sum = {1'b0, line_reg} + {1'b0, snl_reg};
    assign line_inc = (line_reg == LINE_MAX) ? LINE_MAX : line_reg + 1'b1;
    assign snl_inc  = (snl_reg == LINE_MAX) ? LINE_MAX : snl_reg + 1'b1;

    always_comb
    begin
        pk_ok = 1'b1;
        pk    = KIND_NONE;
        case (in_byte)
            ";":     pk = KIND_END_STMT;
            "<":     pk = KIND_LOGIC;
            ">":     pk = KIND_LOGIC;
            "(":     pk = KIND_LPAREN;
            ")":     pk = KIND_RPAREN;
            "=":     pk = KIND_ASSIGN;
            "{":     pk = KIND_LBRACE;
            "}":     pk = KIND_RBRACE;
            "[":     pk = KIND_LBRACKET;
            "]":     pk = KIND_RBRACKET;
            ",":     pk = KIND_COMMA;
            ":":     pk = KIND_COLON;
            default: pk_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        dot_next   = dot_reg;
        quote_next = quote_reg;
        held_next  = held_reg;
        kw_next    = kw_reg;
        line_next  = line_reg;
        snl_next   = snl_reg;
        do_start   = 1'b0;
        e0         = 1'b0;
        e1         = 1'b0;
        st_en      = 1'b0;
        res0       = mk(KIND_NONE, 8'd0, 1'b0, 1'b0, ERR_NONE, line_reg);
        res1       = res0;
        st_res     = res0;

        if (in_cmd == CMD_RESTART)
        begin
            mode_next  = M_IDLE;
            dot_next   = 1'b0;
            quote_next = 1'b0;
            held_next  = 8'd0;
            kw_next    = KW_EMPTY;
            line_next  = LINE_BITS'(1);
            snl_next   = '0;
        end
        else if (in_cmd == CMD_END && mode_reg != M_HALTED)
        begin
            mode_next  = M_IDLE;
            dot_next   = 1'b0;
            quote_next = 1'b0;
            held_next  = 8'd0;
            kw_next    = KW_EMPTY;
            line_next  = LINE_BITS'(1);
            snl_next   = '0;
            case (mode_reg)
                M_NUMBER:
                begin
                    e0   = 1'b1;
                    res0 = mk(KIND_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE, line_reg);
                end
                M_NAME:
                begin
                    e0   = 1'b1;
                    res0 = mk((kw_reg == KW_FULL) ? KIND_LOGIC : KIND_NAME,
                              8'd0, 1'b0, 1'b1, ERR_NONE, line_reg);
                end
                M_STRING, M_OPERATOR:
                begin
                    // An error keeps the rest of the state and halts.
                    e0         = 1'b1;
                    res0       = mk(KIND_NONE, 8'd0, 1'b0, 1'b0,
                                    (mode_reg == M_STRING) ? ERR_OPEN_STR : ERR_OP_AT_END,
                                    line_reg);
                    mode_next  = M_HALTED;
                    dot_next   = dot_reg;
                    quote_next = quote_reg;
                    held_next  = held_reg;
                    kw_next    = kw_reg;
                    line_next  = line_reg;
                    snl_next   = snl_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_cmd == CMD_BYTE && mode_reg != M_HALTED)
        begin
            case (mode_reg)
                M_NUMBER:
                begin
                    if (is_digit(in_byte))
                    begin
                        e0   = 1'b1;
                        res0 = mk(KIND_NONE, in_byte, 1'b1, 1'b0, ERR_NONE, line_reg);
                    end
                    else if (in_byte == ".")
                    begin
                        e0 = 1'b1;
                        if (dot_reg)
                        begin
                            res0      = mk(KIND_NONE, 8'd0, 1'b0, 1'b0, ERR_SECOND_DOT,
                                           line_reg);
                            mode_next = M_HALTED;
                        end
                        else
                        begin
                            dot_next = 1'b1;
                            res0     = mk(KIND_NONE, in_byte, 1'b1, 1'b0, ERR_NONE, line_reg);
                        end
                    end
                    else
                    begin
                        e0        = 1'b1;
                        res0      = mk(KIND_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE, line_reg);
                        mode_next = M_IDLE;
                        do_start  = 1'b1;
                    end
                end
                M_NAME:
                begin
                    if (is_alpha(in_byte) || is_digit(in_byte))
                    begin
                        kw_next = kw_step(kw_reg, in_byte);
                        e0      = 1'b1;
                        res0    = mk(KIND_NONE, in_byte, 1'b1, 1'b0, ERR_NONE, line_reg);
                    end
                    else
                    begin
                        e0        = 1'b1;
                        res0      = mk((kw_reg == KW_FULL) ? KIND_LOGIC : KIND_NAME,
                                       8'd0, 1'b0, 1'b1, ERR_NONE, line_reg);
                        mode_next = M_IDLE;
                        kw_next   = KW_EMPTY;
                        do_start  = 1'b1;
                    end
                end
                M_STRING:
                begin
                    e0 = 1'b1;
                    if (in_byte == (quote_reg ? 8'h27 : 8'h22))
                    begin
                        res0      = mk(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE, line_reg);
                        line_next = line_sum[LINE_BITS] ? LINE_MAX : line_sum[LINE_BITS-1:0];
                        snl_next  = '0;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        if (in_byte == 8'h0A)
                        begin
                            snl_next = snl_inc;
                        end
                        res0 = mk(KIND_NONE, in_byte, 1'b1, 1'b0, ERR_NONE, line_reg);
                    end
                end
                M_COMMENT:
                begin
                    if (in_byte == 8'h0A)
                    begin
                        line_next = line_inc;
                        mode_next = M_IDLE;
                    end
                end
                M_OPERATOR:
                begin
                    held_next = 8'd0;
                    e0        = 1'b1;
                    if (held_reg == "-" && (is_digit(in_byte) || in_byte == "."))
                    begin
                        e1        = 1'b1;
                        res0      = mk(KIND_NONE, "-", 1'b1, 1'b0, ERR_NONE, line_reg);
                        res1      = mk(KIND_NONE, in_byte, 1'b1, 1'b0, ERR_NONE, line_reg);
                        mode_next = M_NUMBER;
                        dot_next  = (in_byte == ".");
                    end
                    else
                    begin
                        res0      = mk(KIND_MATH, held_reg, 1'b1, 1'b1, ERR_NONE, line_reg);
                        mode_next = M_IDLE;
                        do_start  = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                    do_start  = 1'b1;
                end
            endcase

            if (do_start)
            begin
                if (pk_ok)
                begin
                    st_en  = 1'b1;
                    st_res = mk(pk, in_byte, 1'b1, 1'b1, ERR_NONE, line_reg);
                end
                else if (in_byte == 8'h0A)
                begin
                    line_next = line_inc;
                end
                else if (in_byte == " " || in_byte == 8'h09)
                begin
                end
                else if (in_byte == "#")
                begin
                    mode_next = M_COMMENT;
                end
                else if (in_byte == 8'h22 || in_byte == 8'h27)
                begin
                    mode_next  = M_STRING;
                    quote_next = (in_byte == 8'h27);
                    snl_next   = '0;
                end
                else if (is_math(in_byte))
                begin
                    mode_next = M_OPERATOR;
                    held_next = in_byte;
                end
                else if (is_digit(in_byte) || in_byte == ".")
                begin
                    mode_next = M_NUMBER;
                    dot_next  = (in_byte == ".");
                    st_en     = 1'b1;
                    st_res    = mk(KIND_NONE, in_byte, 1'b1, 1'b0, ERR_NONE, line_reg);
                end
                else if (is_alpha(in_byte))
                begin
                    mode_next = M_NAME;
                    kw_next   = kw_step(KW_EMPTY, in_byte);
                    st_en     = 1'b1;
                    st_res    = mk(KIND_NONE, in_byte, 1'b1, 1'b0, ERR_NONE, line_reg);
                end
                else
                begin
                    mode_next = M_HALTED;
                    st_en     = 1'b1;
                    st_res    = mk(KIND_NONE, in_byte, 1'b1, 1'b0, ERR_UNKNOWN, line_reg);
                end

                if (e0)
                begin
                    e1   = st_en;
                    res1 = st_res;
                end
                else
                begin
                    e0   = st_en;
                    res0 = st_res;
                end
            end
        end
    end

    always_comb
    begin
        push.r0  = res0;
        push.r1  = res1;
        push.num = accept ? ({1'b0, e0} + {1'b0, e1}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            dot_reg   <= 1'b0;
            quote_reg <= 1'b0;
            held_reg  <= 8'd0;
            kw_reg    <= KW_EMPTY;
            line_reg  <= LINE_BITS'(1);
            snl_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            dot_reg   <= dot_next;
            quote_reg <= quote_next;
            held_reg  <= held_next;
            kw_reg    <= kw_next;
            line_reg  <= line_next;
            snl_reg   <= snl_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sct_queue.sv =====
// Result queue between front and back: takes up to two results and gives one per cycle when popped.
`default_nettype none

module sct_queue
    import sct_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire push_t             push,
    input  wire logic              pop,
    output logic                   head_valid,
    output res_t                   head,
    output logic [QCNT_W-1:0]      count
);

    res_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wptr_plus;

    assign wptr_plus  = QPTR_W'(wptr_reg + 1'b1);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wptr_reg] <= push.r0;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wptr_plus] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= QPTR_W'(wptr_reg + push.num);
            rptr_reg  <= QPTR_W'(rptr_reg + pop);
            count_reg <= QCNT_W'(count_reg + push.num - pop);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sct_back.sv =====
// Back end: output register that packs queued results onto the master stream.
`default_nettype none

module sct_back
    import sct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire res_t                  head,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [OUT_USER_W-1:0]      m_tuser,
    output logic                       m_tlast
);

    logic valid_reg;
    res_t data_reg;

    assign pop      = head_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tlast  = data_reg.token_end;
    assign m_tuser  = {data_reg.has_byte, data_reg.kind};
    assign m_tdata  = {5'd0, data_reg.err, data_reg.line, data_reg.text};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_tready)
        begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/source_char_tokenizer_top.sv =====
// Source character tokenizer: one source byte or command per transfer, token text out.
// A result passes through the queue memory and the output register before the master side offers it.
// Throughput: one input transfer per cycle while s_tready is high; the front end scans one byte per cycle.
// Results leave at one per cycle while m_tready is high, so items that make two results
// fill the four-entry queue, and input then pauses until the queue has room for two more results.
// Reset (rst_n low, asynchronous) empties the queue and returns the scanner to idle, line 1.
`default_nettype none

module source_char_tokenizer_top
    import sct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] source_byte
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // [1:0] command
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [7:0] text_byte, [31:8] line, [34:32] error_code
    output logic [OUT_USER_W-1:0]      m_tuser,   // [3:0] token_kind, [4] has_byte
    output logic                       m_tlast    // token_end
);

    push_t             push;
    logic              pop;
    logic              head_valid;
    res_t              head;
    logic [QCNT_W-1:0] q_count;

    sct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .in_byte  (s_tdata),
        .q_count  (q_count),
        .push     (push)
    );

    sct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    sct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hdl/sct_checker.sv =====
// Port-level checks on the tokenizer's result stream, bound to the top level.
`default_nettype none

module sct_checker
    import sct_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [OUT_USER_W-1:0] m_tuser,
    input wire logic                  m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34:32] != ERR_NONE |-> !m_tlast && m_tuser[3:0] == KIND_NONE)
        else $error("error result carries a token end or kind");

    a_kind_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser[3:0] == KIND_NONE)
        else $error("token kind outside a token end");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[4] |-> m_tdata[7:0] == 8'd0)
        else $error("text byte set without has_byte");

endmodule

bind source_char_tokenizer_top sct_checker u_sct_checker (.*);

`default_nettype wire

// ===== sim/token_stream_checker.sv =====
// Tokenizer checker: predicts every result from the input transfers and checks the output.

module token_stream_checker
    import sct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] source_byte
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // [1:0] command
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] text_byte, [31:8] line, [34:32] error_code
    input  wire logic [OUT_USER_W-1:0] m_tuser,   // [3:0] token_kind, [4] has_byte
    input  wire logic                  m_tlast,   // token_end
    output int                         mismatch_count,
    output int                         tokens_outstanding,
    output int                         results_checked,
    output int                         tokens_closed,
    output int                         error_results
);

    localparam int LINE_LSB = 8;
    localparam int ERR_LSB  = LINE_LSB + LINE_W;
    localparam int PAD_LSB  = ERR_LSB + 3;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_NAME,
        SCAN_STRING,
        SCAN_COMMENT,
        SCAN_OPERATOR,
        SCAN_HALTED
    } scan_mode_e;

    // Progress of the current name through eq, neq, leq, geq, and, or.
    typedef enum logic [3:0] {
        KW_EMPTY,
        KW_E,
        KW_X,
        KW_XE,
        KW_A,
        KW_AN,
        KW_O,
        KW_FULL,
        KW_DEAD
    } keyword_state_e;

    scan_mode_e           mode;
    logic                 dot_seen;
    logic                 single_quote;
    logic [7:0]           held_op;
    keyword_state_e       keyword;
    logic [LINE_BITS-1:0] line_count;
    logic [LINE_BITS-1:0] string_newlines;
    res_t                 predicted_tokens[$];

    function automatic logic [LINE_BITS-1:0] sat_add(input logic [LINE_BITS-1:0] a,
                                                     input logic [LINE_BITS-1:0] b);
        logic [LINE_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum[LINE_BITS])
            return LINE_MAX;
        return sum[LINE_BITS-1:0];
    endfunction

    function automatic void clear_scanner();
        mode            = SCAN_IDLE;
        dot_seen        = 1'b0;
        single_quote    = 1'b0;
        held_op         = 8'd0;
        keyword         = KW_EMPTY;
        line_count      = LINE_BITS'(1);
        string_newlines = '0;
    endfunction

    function automatic void push_token(input logic [3:0] kind, input logic [7:0] text,
                                       input logic has, input logic last,
                                       input logic [2:0] err);
        res_t r;
        r.kind      = kind;
        r.text      = text;
        r.has_byte  = has;
        r.token_end = last;
        r.line      = line_count[LINE_W-1:0];
        r.err       = err;
        predicted_tokens.push_back(r);
    endfunction

    function automatic void raise_error(input logic [2:0] err, input logic [7:0] text,
                                        input logic has);
        push_token(KIND_NONE, text, has, 1'b0, err);
        mode = SCAN_HALTED;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_math(input logic [7:0] c);
        return c == "+" || c == "-" || c == "/" || c == "*" || c == "%";
    endfunction

    function automatic keyword_state_e keyword_next(input keyword_state_e s,
                                                    input logic [7:0] c);
        case (s)
            KW_EMPTY:
            begin
                if (c == "e")
                    return KW_E;
                if (c == "n" || c == "l" || c == "g")
                    return KW_X;
                if (c == "a")
                    return KW_A;
                if (c == "o")
                    return KW_O;
            end
            KW_E, KW_XE:
            begin
                if (c == "q")
                    return KW_FULL;
            end
            KW_X:
            begin
                if (c == "e")
                    return KW_XE;
            end
            KW_A:
            begin
                if (c == "n")
                    return KW_AN;
            end
            KW_AN:
            begin
                if (c == "d")
                    return KW_FULL;
            end
            KW_O:
            begin
                if (c == "r")
                    return KW_FULL;
            end
            default:
            begin
            end
        endcase
        return KW_DEAD;
    endfunction

    function automatic bit punct_kind(input logic [7:0] c, output logic [3:0] kind);
        kind = KIND_NONE;
        case (c)
            ";":      kind = KIND_END_STMT;
            "<", ">": kind = KIND_LOGIC;
            "(":      kind = KIND_LPAREN;
            ")":      kind = KIND_RPAREN;
            "=":      kind = KIND_ASSIGN;
            "{":      kind = KIND_LBRACE;
            "}":      kind = KIND_RBRACE;
            "[":      kind = KIND_LBRACKET;
            "]":      kind = KIND_RBRACKET;
            ",":      kind = KIND_COMMA;
            ":":      kind = KIND_COLON;
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [3:0] name_kind();
        if (keyword == KW_FULL)
            return KIND_LOGIC;
        return KIND_NAME;
    endfunction

    function automatic void start_char(input logic [7:0] c);
        logic [3:0] kind;
        if (punct_kind(c, kind))
            push_token(kind, c, 1'b1, 1'b1, ERR_NONE);
        else if (c == "\n")
            line_count = sat_add(line_count, LINE_BITS'(1));
        else if (c == " " || c == "\t")
        begin
        end
        else if (c == "#")
            mode = SCAN_COMMENT;
        else if (c == "\"" || c == "'")
        begin
            mode            = SCAN_STRING;
            single_quote    = (c == "'");
            string_newlines = '0;
        end
        else if (is_math(c))
        begin
            mode    = SCAN_OPERATOR;
            held_op = c;
        end
        else if (is_digit(c) || c == ".")
        begin
            mode     = SCAN_NUMBER;
            dot_seen = (c == ".");
            push_token(KIND_NONE, c, 1'b1, 1'b0, ERR_NONE);
        end
        else if (is_alpha(c))
        begin
            mode    = SCAN_NAME;
            keyword = keyword_next(KW_EMPTY, c);
            push_token(KIND_NONE, c, 1'b1, 1'b0, ERR_NONE);
        end
        else
            raise_error(ERR_UNKNOWN, c, 1'b1);
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        logic [7:0] closing;
        case (mode)
            SCAN_NUMBER:
            begin
                if (is_digit(c))
                    push_token(KIND_NONE, c, 1'b1, 1'b0, ERR_NONE);
                else if (c == "." && dot_seen)
                    raise_error(ERR_SECOND_DOT, 8'd0, 1'b0);
                else if (c == ".")
                begin
                    dot_seen = 1'b1;
                    push_token(KIND_NONE, c, 1'b1, 1'b0, ERR_NONE);
                end
                else
                begin
                    push_token(KIND_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE);
                    mode = SCAN_IDLE;
                    start_char(c);
                end
            end
            SCAN_NAME:
            begin
                if (is_alpha(c) || is_digit(c))
                begin
                    keyword = keyword_next(keyword, c);
                    push_token(KIND_NONE, c, 1'b1, 1'b0, ERR_NONE);
                end
                else
                begin
                    push_token(name_kind(), 8'd0, 1'b0, 1'b1, ERR_NONE);
                    mode    = SCAN_IDLE;
                    keyword = KW_EMPTY;
                    start_char(c);
                end
            end
            SCAN_STRING:
            begin
                if (single_quote)
                    closing = "'";
                else
                    closing = "\"";
                if (c == closing)
                begin
                    // The end marker still carries the line the string opened on.
                    push_token(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE);
                    line_count      = sat_add(line_count, string_newlines);
                    string_newlines = '0;
                    mode            = SCAN_IDLE;
                end
                else
                begin
                    if (c == "\n")
                        string_newlines = sat_add(string_newlines, LINE_BITS'(1));
                    push_token(KIND_NONE, c, 1'b1, 1'b0, ERR_NONE);
                end
            end
            SCAN_COMMENT:
            begin
                if (c == "\n")
                begin
                    line_count = sat_add(line_count, LINE_BITS'(1));
                    mode       = SCAN_IDLE;
                end
            end
            SCAN_OPERATOR:
            begin
                if (held_op == "-" && (is_digit(c) || c == "."))
                begin
                    push_token(KIND_NONE, "-", 1'b1, 1'b0, ERR_NONE);
                    push_token(KIND_NONE, c, 1'b1, 1'b0, ERR_NONE);
                    mode     = SCAN_NUMBER;
                    dot_seen = (c == ".");
                    held_op  = 8'd0;
                end
                else
                begin
                    push_token(KIND_MATH, held_op, 1'b1, 1'b1, ERR_NONE);
                    held_op = 8'd0;
                    mode    = SCAN_IDLE;
                    start_char(c);
                end
            end
            default:
            begin
                mode = SCAN_IDLE;
                start_char(c);
            end
        endcase
    endfunction

    function automatic void finish_source();
        case (mode)
            SCAN_STRING:
                raise_error(ERR_OPEN_STR, 8'd0, 1'b0);
            SCAN_OPERATOR:
                raise_error(ERR_OP_AT_END, 8'd0, 1'b0);
            default:
            begin
                if (mode == SCAN_NUMBER)
                    push_token(KIND_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE);
                else if (mode == SCAN_NAME)
                    push_token(name_kind(), 8'd0, 1'b0, 1'b1, ERR_NONE);
                clear_scanner();
            end
        endcase
    endfunction

    function automatic void tokenize_step(input logic [1:0] cmd, input logic [7:0] c);
        if (cmd == CMD_RESTART)
            clear_scanner();
        else if (mode == SCAN_HALTED)
        begin
        end
        else if (cmd == CMD_END)
            finish_source();
        else if (cmd == CMD_BYTE)
            scan_char(c);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t seen;
        res_t want;
        if (!rst_n)
        begin
            clear_scanner();
            predicted_tokens.delete();
            mismatch_count     = 0;
            tokens_outstanding = 0;
            results_checked    = 0;
            tokens_closed      = 0;
            error_results      = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.kind      = m_tuser[3:0];
                seen.has_byte  = m_tuser[4];
                seen.text      = m_tdata[7:0];
                seen.line      = m_tdata[LINE_LSB +: LINE_W];
                seen.err       = m_tdata[ERR_LSB +: 3];
                seen.token_end = m_tlast;
                results_checked++;
                if (predicted_tokens.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display({"%0t: unpredicted result kind %0d text %h has %b",
                                  " end %b line %0d err %0d"},
                                 $realtime, seen.kind, seen.text, seen.has_byte,
                                 seen.token_end, seen.line, seen.err);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_tokens.pop_front();
                    if (want.token_end)
                        tokens_closed++;
                    if (want.err != ERR_NONE)
                        error_results++;
                    if (seen.kind !== want.kind || seen.text !== want.text ||
                        seen.has_byte !== want.has_byte ||
                        seen.token_end !== want.token_end ||
                        seen.line !== want.line || seen.err !== want.err ||
                        m_tdata[OUT_DATA_W-1:PAD_LSB] !== '0)
                    begin
                        if (mismatch_count < 10)
                            $display({"%0t: mismatch (want/got) kind %0d/%0d text %h/%h",
                                      " has %b/%b end %b/%b line %0d/%0d err %0d/%0d pad %h"},
                                     $realtime, want.kind, seen.kind, want.text, seen.text,
                                     want.has_byte, seen.has_byte,
                                     want.token_end, seen.token_end,
                                     want.line, seen.line, want.err, seen.err,
                                     m_tdata[OUT_DATA_W-1:PAD_LSB]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                tokenize_step(s_tuser, s_tdata);
            tokens_outstanding = predicted_tokens.size();
        end
    end

endmodule

// ===== sim/source_char_tokenizer_top_test.sv =====
// Testbench top for the source character tokenizer: stimulus, flow control and verdict.

module source_char_tokenizer_top_test;
    import sct_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;

    localparam string ALPHA_CHARS  = "abcdeglnoqrxyzABCDEFGHIJKLMNOPQRSTUVWXYZfhijkmpstuvw_";
    localparam string ALNUM_CHARS  = "abcdeglnoqrXYZ_0123456789";
    localparam string PUNCT_CHARS  = ";<>(){}[],:=";
    localparam string MATH_CHARS   = "+-/*%";
    localparam string BLANK_CHARS  = "     \t\n";

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    int mismatch_count;
    int tokens_outstanding;
    int results_checked;
    int tokens_closed;
    int error_results;

    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int ready_style = 0;
    int style_left  = 0;

    string keyword_words[10] = '{"eq", "neq", "leq", "geq", "and", "or",
                                 "an", "ne", "orx", "eqq"};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    source_char_tokenizer_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    token_stream_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser),
        .m_tlast            (m_tlast),
        .mismatch_count     (mismatch_count),
        .tokens_outstanding (tokens_outstanding),
        .results_checked    (results_checked),
        .tokens_closed      (tokens_closed),
        .error_results      (error_results)
    );

    // The receiver switches between always ready, light stalls and heavy stalls.
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            style_left  <= $urandom_range(16, 96);
            ready_style <= $urandom_range(0, 2);
        end
        else
            style_left <= style_left - 1;
        case (ready_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_item(CMD_BYTE, text[i]);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (tokens_outstanding != 0);
        @(posedge clk);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0, 1:    send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
            2:       send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
            3:       send_item(CMD_END, 8'($urandom_range(0, 255)));
            default: send_item(CMD_RESTART, 8'($urandom_range(0, 255)));
        endcase
    endtask

    // One random token, blank or comment; broken marks a deliberately bad one.
    task automatic send_fragment(output bit broken);
        int         len;
        int         pick;
        logic [7:0] quote;
        logic [7:0] ch;
        broken = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            if ($urandom_range(0, 2) == 0)
                send_text(keyword_words[$urandom_range(0, 9)]);
            else
            begin
                send_item(CMD_BYTE, pick_char(ALPHA_CHARS));
                len = $urandom_range(0, 5);
                repeat (len) send_item(CMD_BYTE, pick_char(ALNUM_CHARS));
            end
        end
        else if (pick < 40)
        begin
            if ($urandom_range(0, 2) == 0)
                send_item(CMD_BYTE, "-");
            len = $urandom_range(1, 5);
            pick = $urandom_range(0, len);
            for (int i = 0; i < len; i++)
                send_item(CMD_BYTE, (i == pick) ? 8'h2e : pick_char("0123456789"));
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(CMD_BYTE, ".");
                broken = 1'b1;
            end
        end
        else if (pick < 50)
        begin
            quote = ($urandom_range(0, 1) == 0) ? 8'h22 : 8'h27;
            send_item(CMD_BYTE, quote);
            len = $urandom_range(0, 8);
            repeat (len)
            begin
                do
                begin
                    case ($urandom_range(0, 5))
                        0:       ch = "\n";
                        1:       ch = 8'($urandom_range(0, 255));
                        default: ch = 8'($urandom_range(32, 126));
                    endcase
                end
                while (ch == quote);
                send_item(CMD_BYTE, ch);
            end
            if ($urandom_range(0, 9) == 0)
                broken = 1'b1;
            else
                send_item(CMD_BYTE, quote);
        end
        else if (pick < 66)
            send_item(CMD_BYTE, pick_char(PUNCT_CHARS));
        else if (pick < 78)
            send_item(CMD_BYTE, pick_char(MATH_CHARS));
        else if (pick < 92)
            send_item(CMD_BYTE, pick_char(BLANK_CHARS));
        else
        begin
            send_item(CMD_BYTE, "#");
            len = $urandom_range(0, 6);
            repeat (len)
            begin
                do
                    ch = 8'($urandom_range(0, 255));
                while (ch == "\n");
                send_item(CMD_BYTE, ch);
            end
            if ($urandom_range(0, 7) != 0)
                send_item(CMD_BYTE, "\n");
        end
    endtask

    task automatic send_program();
        int fragments;
        bit noisy;
        bit broken;
        noisy = 1'b0;
        fragments = $urandom_range(2, 30);
        repeat (fragments)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                send_noise();
                noisy = 1'b1;
            end
            else
            begin
                send_fragment(broken);
                noisy |= broken;
            end
            if ($urandom_range(0, 3) != 0)
                send_item(CMD_BYTE, pick_char(BLANK_CHARS));
        end
        send_item(CMD_END, 8'($urandom_range(0, 255)));
        if (noisy || $urandom_range(0, 1) == 0)
            send_item(CMD_RESTART, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_directed();
        send_text("or<-2");
        send_item(CMD_END, 8'h00);
        send_text("'\n'");
        send_text("#\n");
        send_text("1..");
        send_item(CMD_RESTART, 8'hff);
        send_text("\"x");
        send_item(CMD_END, 8'h00);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_RESTART, 8'h00);
        send_text("*");
        send_item(CMD_END, 8'hff);
        send_item(CMD_RESTART, 8'h55);
        send_item(CMD_BYTE, 8'hff);
        send_item(CMD_UNUSED, 8'haa);
        send_item(CMD_RESTART, 8'h00);
    endtask

    initial
    begin
        int directed_items;
        int program_count;
        program_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain_results();
        directed_items = items_sent;
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            send_program();
            program_count++;
            if (program_count % 8 == 0)
                drain_results();
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d transfers (%0d directed, %0d random programs).",
                 items_sent, directed_items, program_count);
        $display("Checked %0d results: %0d token ends, %0d error results, %0d mismatches.",
                 results_checked, tokens_closed, error_results, mismatch_count);
        if (mismatch_count == 0 && tokens_outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sct_pkg.sv
hdl/sct_front.sv
hdl/sct_queue.sv
hdl/sct_back.sv
hdl/source_char_tokenizer_top.sv
hdl/sct_checker.sv
sim/token_stream_checker.sv
sim/source_char_tokenizer_top_test.sv
